@@ hdl/gve_pkg.sv @@
`timescale 1ns / 1ps
package gve_pkg;
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int DIM_W = 7;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_RUN = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_RUN = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_COLS = 2'd0,
		REG_ROWS = 2'd1,
		REG_LAYERS = 2'd2
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_LAYER,
		ST_NB_ADDR,
		ST_NB_WAIT,
		ST_CELL_DONE,
		ST_COPY,
		ST_COPY_WAIT,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic read_rd;
		logic cell_start;
		logic nb_issue;
		logic nb_take;
		logic cell_write;
		logic copy_rd;
		logic copy_wr;
		logic div_start;
		logic div_step;
		logic next_cell;
		logic layer_start;
		logic pos_start;
		logic pos_step;
	} cmd_t;

	typedef struct packed {
		logic pos_fresh;
		logic pos_done;
		logic nb_last;
		logic cell_last;
		logic div_done;
	} sts_t;
endpackage

@@ hdl/gve_ctrl.sv @@
`timescale 1ns / 1ps
module gve_ctrl import gve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] opcode,
	output logic in_stall,
	input logic out_full,
	input logic [3:0] layer_count,
	input sts_t sts,
	output cmd_t cmd,
	output logic res_load,
	output kind_t res_kind
);
	state_t state_q, state_d;
	logic [3:0] layer_q, layer_d;
	kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= '0;
			kind_q <= KIND_LOAD;
		end else begin
			state_q <= state_d;
			layer_q <= layer_d;
			kind_q <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		layer_d = layer_q;
		kind_d = kind_q;
		cmd = '0;
		res_load = 1'b0;
		res_kind = kind_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (!sts.pos_fresh) begin
					cmd.pos_start = 1'b1;
					state_d = ST_LOAD;
				end else begin
					in_stall = 1'b0;
					if (in_valid) begin
						case (opcode)
							OP_LOAD: begin
								cmd.load_wr = 1'b1;
								kind_d = KIND_LOAD;
								state_d = ST_OUT;
							end
							OP_RUN: begin
								kind_d = KIND_RUN;
								layer_d = '0;
								state_d = ST_LAYER;
							end
							OP_READ: begin
								cmd.read_rd = 1'b1;
								kind_d = KIND_READ;
								state_d = ST_READ;
							end
							default: ;
						endcase
					end
				end
			end
			ST_LOAD: begin
				cmd.pos_step = 1'b1;
				if (sts.pos_done) state_d = ST_IDLE;
			end
			ST_READ: state_d = ST_OUT;
			ST_LAYER: begin
				if (layer_q == layer_count) state_d = ST_OUT;
				else begin
					cmd.layer_start = 1'b1;
					state_d = ST_NB_ADDR;
				end
			end
			ST_NB_ADDR: begin
				cmd.nb_issue = 1'b1;
				state_d = ST_NB_WAIT;
			end
			ST_NB_WAIT: begin
				cmd.nb_take = 1'b1;
				if (sts.nb_last) state_d = ST_DIV;
				else state_d = ST_NB_ADDR;
				if (sts.nb_last) cmd.div_start = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_CELL_DONE;
			end
			ST_CELL_DONE: begin
				cmd.cell_write = 1'b1;
				cmd.next_cell = 1'b1;
				if (sts.cell_last) begin
					cmd.cell_start = 1'b1;
					state_d = ST_COPY;
				end else state_d = ST_NB_ADDR;
			end
			ST_COPY: begin
				cmd.copy_rd = 1'b1;
				state_d = ST_COPY_WAIT;
			end
			ST_COPY_WAIT: begin
				cmd.copy_wr = 1'b1;
				cmd.next_cell = 1'b1;
				if (sts.cell_last) begin
					layer_d = layer_q + 4'd1;
					state_d = ST_LAYER;
				end else state_d = ST_COPY;
			end
			ST_OUT: begin
				if (!out_full) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_layer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY_WAIT) |-> (layer_q < layer_count))
		else $error("layer counter past count");
	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (state_q == ST_OUT))
		else $error("result outside output state");
	a_idle_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
endmodule

@@ hdl/gve_datapath.sv @@
`timescale 1ns / 1ps
module gve_datapath import gve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input logic [DIM_W-1:0] cols,
	input logic [DIM_W-1:0] rows,
	input logic signed [31:0] cell_value,
	input logic [16:0] face_weight,
	input logic signed [31:0] phi_here,
	input logic signed [31:0] phi_beside,
	input logic [11:0] cell_index,
	output logic signed [31:0] rd_value,
	output logic rd_valid
);
	logic signed [31:0] val_now [CELLS];
	logic signed [31:0] val_next [CELLS];
	logic vld_now [CELLS];
	logic vld_next [CELLS];

	logic [AW:0] ncells;
	logic [AW-1:0] load_pos_q;
	logic [DIM_W-1:0] load_r_q, load_c_q;
	logic [DIM_W-1:0] cur_r_q, cur_c_q;
	logic [AW-1:0] cur_q;
	logic [1:0] nb_q;
	logic signed [33:0] sum_q;
	logic [2:0] cnt_q;
	logic self_vld_q;
	logic signed [31:0] self_val_q;
	logic rd_oor_q;
	logic signed [31:0] nrd_val_q;
	logic nrd_vld_q;
	logic nb_ok_q;
	logic [AW-1:0] nb_addr;
	logic nb_ok;
	logic interior_cur, interior_load;
	logic wet, last_r, last_c;

	// load position split into row and column after a column change
	logic [DIM_W-1:0] pos_cols_q;
	logic [AW-1:0] pdiv_q, pquo_q;
	logic [DIM_W-1:0] prem_q;
	logic [3:0] pstep_q;
	logic [DIM_W:0] pt, pt_sub;
	logic pos_wrap;
	logic [AW-1:0] load_p;
	logic [DIM_W-1:0] load_r, load_c;

	// rounding divide by count, restoring, one bit per cycle
	logic [34:0] rem_q;
	logic [33:0] quo_q;
	logic [33:0] mag_q;
	logic neg_q;
	logic [5:0] dbit_q;
	logic signed [31:0] avg;

	assign ncells = (AW+1)'(cols) * (AW+1)'(rows);
	assign pos_wrap = {1'b0, load_pos_q} >= ncells;
	assign load_p = pos_wrap ? '0 : load_pos_q;
	assign load_r = pos_wrap ? '0 : load_r_q;
	assign load_c = pos_wrap ? '0 : load_c_q;
	assign pt = {prem_q, pdiv_q[AW-1]};
	assign pt_sub = pt - {1'b0, cols};
	assign interior_cur = cur_r_q != '0 && cur_r_q != rows - 1'b1 &&
		cur_c_q != '0 && cur_c_q != cols - 1'b1;
	assign interior_load = load_r != '0 && load_r != rows - 1'b1 &&
		load_c != '0 && load_c != cols - 1'b1;
	assign wet = phi_here[31] | phi_beside[31];
	assign last_c = cur_c_q == cols - 1'b1;
	assign last_r = cur_r_q == rows - 1'b1;

	always_comb begin
		case (nb_q)
			2'd0: nb_addr = cur_q + 1'b1;
			2'd1: nb_addr = cur_q - 1'b1;
			2'd2: nb_addr = cur_q + AW'(cols);
			default: nb_addr = cur_q - AW'(cols);
		endcase
	end
	assign nb_ok = interior_cur;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			val_now[load_p] <= cell_value;
			vld_now[load_p] <= interior_load && face_weight != '0 && wet;
		end
		if (cmd.read_rd) begin
			nrd_val_q <= val_now[cell_index[AW-1:0]];
			nrd_vld_q <= vld_now[cell_index[AW-1:0]];
			rd_oor_q <= {1'b0, cell_index} >= 13'(ncells);
		end
		if (cmd.nb_issue) begin
			nrd_val_q <= val_now[nb_addr];
			nrd_vld_q <= vld_now[nb_addr];
			self_val_q <= val_now[cur_q];
			self_vld_q <= vld_now[cur_q];
			nb_ok_q <= nb_ok;
		end
		if (cmd.cell_write) begin
			if (nb_ok_q && !self_vld_q && cnt_q != '0) begin
				val_next[cur_q] <= avg;
				vld_next[cur_q] <= 1'b1;
			end else begin
				val_next[cur_q] <= self_val_q;
				vld_next[cur_q] <= self_vld_q;
			end
		end
		if (cmd.copy_rd) begin
			nrd_val_q <= val_next[cur_q];
			nrd_vld_q <= vld_next[cur_q];
		end
		if (cmd.copy_wr) begin
			val_now[cur_q] <= nrd_val_q;
			vld_now[cur_q] <= nrd_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			load_r_q <= '0;
			load_c_q <= '0;
			cur_q <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			nb_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
			dbit_q <= '0;
			pos_cols_q <= DIM_W'(MAX_COLS);
			pdiv_q <= '0;
			pquo_q <= '0;
			prem_q <= '0;
			pstep_q <= '0;
		end else begin
			if (cmd.load_wr) begin
				if ({1'b0, load_p} == ncells - 1'b1) begin
					load_pos_q <= '0;
					load_r_q <= '0;
					load_c_q <= '0;
				end else begin
					load_pos_q <= load_p + 1'b1;
					if (load_c == cols - 1'b1) begin
						load_c_q <= '0;
						load_r_q <= load_r + 1'b1;
					end else begin
						load_r_q <= load_r;
						load_c_q <= load_c + 1'b1;
					end
				end
			end
			if (cmd.pos_start) begin
				pos_cols_q <= cols;
				pdiv_q <= load_pos_q;
				pquo_q <= '0;
				prem_q <= '0;
				pstep_q <= 4'(AW);
			end else if (cmd.pos_step) begin
				if (pstep_q != '0) begin
					pstep_q <= pstep_q - 1'b1;
					pdiv_q <= {pdiv_q[AW-2:0], 1'b0};
					if (pt >= {1'b0, cols}) begin
						prem_q <= pt_sub[DIM_W-1:0];
						pquo_q <= {pquo_q[AW-2:0], 1'b1};
					end else begin
						prem_q <= pt[DIM_W-1:0];
						pquo_q <= {pquo_q[AW-2:0], 1'b0};
					end
				end else begin
					load_r_q <= pquo_q[DIM_W-1:0];
					load_c_q <= prem_q;
				end
			end
			if (cmd.layer_start || cmd.cell_start) begin
				cur_q <= '0;
				cur_r_q <= '0;
				cur_c_q <= '0;
				nb_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
			end else if (cmd.next_cell) begin
				cur_q <= cur_q + 1'b1;
				nb_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
				if (last_c) begin
					cur_c_q <= '0;
					cur_r_q <= last_r ? '0 : cur_r_q + 1'b1;
				end else cur_c_q <= cur_c_q + 1'b1;
				if (last_c && last_r) cur_q <= '0;
			end
			if (cmd.nb_take) begin
				nb_q <= nb_q + 1'b1;
				if (nb_ok_q && nrd_vld_q) begin
					sum_q <= sum_q + 34'(nrd_val_q);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.div_start) dbit_q <= 6'd34;
			else if (cmd.div_step && dbit_q != '0) dbit_q <= dbit_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			logic signed [33:0] s;
			logic [2:0] c;
			s = sum_q;
			c = cnt_q;
			if (nb_ok_q && nrd_vld_q) begin
				s = sum_q + 34'(nrd_val_q);
				c = cnt_q + 1'b1;
			end
			neg_q <= s[33];
			mag_q <= (s[33] ? 34'(-s) : 34'(s)) + 34'(c >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && dbit_q != '0) begin
			logic [34:0] t;
			t = {rem_q[33:0], mag_q[33]};
			mag_q <= {mag_q[32:0], 1'b0};
			if (t >= 35'(cnt_q)) begin
				rem_q <= t - 35'(cnt_q);
				quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= t;
				quo_q <= {quo_q[32:0], 1'b0};
			end
		end
	end
	assign avg = neg_q ? 32'(-quo_q) : 32'(quo_q);

	assign sts.nb_last = nb_q == 2'd3;
	assign sts.cell_last = last_c && last_r;
	assign sts.div_done = dbit_q == '0;
	assign sts.pos_fresh = pos_cols_q == cols;
	assign sts.pos_done = pstep_q == '0;

	assign rd_value = rd_oor_q ? '0 : nrd_val_q;
	assign rd_valid = rd_oor_q ? 1'b0 : nrd_vld_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_wr |=> ({1'b0, load_pos_q} < ncells || $past(ncells) != ncells))
		else $error("load position out of grid");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("neighbour count overflow");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> dbit_q == 6'd34)
		else $error("divider not armed");
endmodule

@@ hdl/grid_velocity_extrapolation.sv @@
`timescale 1ns / 1ps
// A run processes each layer cell by cell (four neighbour reads and a 34-step restoring
// divide per cell), then makes a copy pass. After the column count changes, the next
// request waits while the load position is split into row and column.
module grid_velocity_extrapolation import gve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] opcode,
	input logic signed [31:0] cell_value,
	input logic [16:0] face_weight,
	input logic signed [31:0] phi_here,
	input logic signed [31:0] phi_beside,
	input logic [11:0] cell_index,
	output logic out_valid_q,
	input logic out_stall,
	output logic [1:0] result_kind,
	output logic signed [31:0] out_value,
	output logic out_valid,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic [6:0] cols_q, rows_q;
	logic [3:0] layers_q;
	logic [DIM_W-1:0] cols_e, rows_e;
	cmd_t cmd;
	sts_t sts;
	logic res_load;
	kind_t res_kind;
	logic signed [31:0] rd_value;
	logic rd_valid;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd64;
			rows_q <= 7'd64;
			layers_q <= 4'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLS: cols_q <= cfg_data[6:0];
				REG_ROWS: rows_q <= cfg_data[6:0];
				REG_LAYERS: layers_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end
	assign cols_e = cols_q < 7'd3 ? 7'd3 : (cols_q > 7'(MAX_COLS) ? 7'(MAX_COLS) : cols_q);
	assign rows_e = rows_q < 7'd3 ? 7'd3 : (rows_q > 7'(MAX_ROWS) ? 7'(MAX_ROWS) : rows_q);

	gve_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .opcode, .in_stall,
		.out_full(out_valid_q && out_stall), .layer_count(layers_q),
		.sts, .cmd, .res_load, .res_kind
	);

	gve_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .cols(cols_e), .rows(rows_e),
		.cell_value, .face_weight, .phi_here, .phi_beside, .cell_index,
		.rd_value, .rd_valid
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_kind <= res_kind;
			out_value <= (res_kind == KIND_READ) ? rd_value : '0;
			out_valid <= (res_kind == KIND_READ) ? rd_valid : 1'b0;
		end
	end
endmodule

@@ test/velocity_field_checker.sv @@
`timescale 1ns / 1ps
module velocity_field_checker import gve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [1:0] opcode,
	input logic signed [31:0] cell_value,
	input logic [16:0] face_weight,
	input logic signed [31:0] phi_here,
	input logic signed [31:0] phi_beside,
	input logic [11:0] cell_index,
	input logic out_valid_q,
	input logic out_stall,
	input logic [1:0] result_kind,
	input logic signed [31:0] out_value,
	input logic out_valid,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output int errors,
	output int pending
);
	typedef struct {
		kind_t kind;
		logic signed [31:0] value;
		logic flag;
	} reply_t;

	reply_t replies[$];
	reply_t want;
	logic signed [31:0] vel_now [CELLS];
	logic signed [31:0] vel_next [CELLS];
	bit set_now [CELLS];
	bit set_next [CELLS];
	int cols_reg, rows_reg, layers_reg, load_pos;

	function automatic int clamp_dim(int v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic signed [31:0] round_mean(longint sum, int cnt);
		longint mag;
		longint q;
		mag = (sum < 0) ? -sum : sum;
		q = (mag + cnt / 2) / cnt;
		return (sum < 0) ? -q : q;
	endfunction

	task automatic grow_layer(int c, int r);
		int i, cnt;
		longint sum;
		for (int k = 0; k < c * r; k++) begin
			vel_next[k] = vel_now[k];
			set_next[k] = set_now[k];
		end
		for (int y = 1; y < r - 1; y++) begin
			for (int x = 1; x < c - 1; x++) begin
				i = y * c + x;
				if (!set_now[i]) begin
					sum = 0;
					cnt = 0;
					if (set_now[i + 1]) begin sum += vel_now[i + 1]; cnt++; end
					if (set_now[i - 1]) begin sum += vel_now[i - 1]; cnt++; end
					if (set_now[i + c]) begin sum += vel_now[i + c]; cnt++; end
					if (set_now[i - c]) begin sum += vel_now[i - c]; cnt++; end
					if (cnt > 0) begin
						vel_next[i] = round_mean(sum, cnt);
						set_next[i] = 1'b1;
					end
				end
			end
		end
		for (int k = 0; k < c * r; k++) begin
			vel_now[k] = vel_next[k];
			set_now[k] = set_next[k];
		end
	endtask

	task automatic predict_request();
		int c, r, n, p, y, x;
		reply_t rep;
		c = clamp_dim(cols_reg, MAX_COLS);
		r = clamp_dim(rows_reg, MAX_ROWS);
		n = c * r;
		rep.value = '0;
		rep.flag = 1'b0;
		case (op_t'(opcode))
			OP_LOAD: begin
				p = (load_pos >= n) ? 0 : load_pos;
				y = p / c;
				x = p % c;
				vel_now[p] = cell_value;
				set_now[p] = y > 0 && y < r - 1 && x > 0 && x < c - 1 && face_weight != 0
					&& (phi_here[31] || phi_beside[31]);
				load_pos = (p + 1 >= n) ? 0 : p + 1;
				rep.kind = KIND_LOAD;
				replies.push_back(rep);
			end
			OP_RUN: begin
				for (int l = 0; l < layers_reg; l++)
					grow_layer(c, r);
				rep.kind = KIND_RUN;
				replies.push_back(rep);
			end
			OP_READ: begin
				rep.kind = KIND_READ;
				if (cell_index < n) begin
					rep.value = vel_now[cell_index];
					rep.flag = set_now[cell_index];
				end
				replies.push_back(rep);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg = 64;
			rows_reg = 64;
			layers_reg = 2;
			load_pos = 0;
			errors = 0;
			replies.delete();
			pending = 0;
		end else begin
			if (out_valid_q && !out_stall) begin
				if (replies.size() == 0) begin
					$display("%0t: unexpected result kind %0d value %h flag %0d", $time,
						result_kind, out_value, out_valid);
					errors = errors + 1;
				end else begin
					want = replies.pop_front();
					if (result_kind !== want.kind || out_value !== want.value
						|| out_valid !== want.flag) begin
						$display("%0t: expected kind %0d value %h flag %0d, got kind %0d value %h flag %0d",
							$time, want.kind, want.value, want.flag, result_kind, out_value,
							out_valid);
						errors = errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_COLS) cols_reg = cfg_data[6:0];
				else if (cfg_index == REG_ROWS) rows_reg = cfg_data[6:0];
				else if (cfg_index == REG_LAYERS) layers_reg = cfg_data[3:0];
			end
			if (in_valid && !in_stall)
				predict_request();
			pending = replies.size();
		end
	end
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import gve_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid_q, out_stall, out_valid;
	logic [1:0] opcode, result_kind, cfg_index;
	logic signed [31:0] cell_value, phi_here, phi_beside, out_value;
	logic [16:0] face_weight;
	logic [11:0] cell_index;
	logic cfg_valid, cfg_ready;
	logic [31:0] cfg_data;
	logic in_taken, cfg_taken;
	int errors, pending, sent, grid_n;

	grid_velocity_extrapolation u_dut (.*);

	velocity_field_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		out_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 60)) @(negedge clk);
			out_stall = 1'b1;
			repeat (gap_len() + 1) @(negedge clk);
			out_stall = 1'b0;
		end
	end

	task automatic send(op_t op, logic [31:0] v, logic [16:0] w, logic [31:0] ph,
		logic [31:0] pb, logic [11:0] idx);
		int g;
		opcode = op;
		cell_value = v;
		face_weight = w;
		phi_here = ph;
		phi_beside = pb;
		cell_index = idx;
		in_valid = 1'b1;
		do @(negedge clk); while (!in_taken);
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic settle();
		in_valid = 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(reg_t idx, logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid = 1'b0;
	endtask

	task automatic resize(logic [31:0] c, logic [31:0] r, logic [31:0] layers);
		int ec, er;
		settle();
		cfg_write(REG_COLS, c);
		cfg_write(REG_ROWS, r);
		cfg_write(REG_LAYERS, layers);
		ec = c[6:0] < 3 ? 3 : (c[6:0] > 64 ? 64 : c[6:0]);
		er = r[6:0] < 3 ? 3 : (r[6:0] > 64 ? 64 : r[6:0]);
		grid_n = ec * er;
	endtask

	task automatic load_cells(int count, int wet_pct, bit extremes);
		logic [31:0] v, ph, pb;
		logic [16:0] w;
		int p;
		for (int k = 0; k < count; k++) begin
			v = $urandom();
			if (extremes) begin
				p = k % 6;
				v = p == 0 ? 32'h7fffffff : p == 1 ? 32'h80000000 : p == 2 ? 32'hffffffff :
					p == 3 ? 32'h0 : p == 4 ? 32'h1 : v;
			end
			p = $urandom_range(0, 9);
			w = p == 0 ? 17'd0 : p == 1 ? 17'd65536 : 17'($urandom_range(1, 65535));
			ph = $urandom();
			pb = $urandom();
			ph[31] = $urandom_range(0, 99) < wet_pct;
			pb[31] = $urandom_range(0, 99) < wet_pct / 2;
			send(OP_LOAD, v, w, ph, pb, 12'($urandom()));
		end
	endtask

	task automatic read_cells(int count);
		logic [11:0] idx;
		for (int k = 0; k < count; k++) begin
			idx = ($urandom_range(0, 4) == 0) ? 12'($urandom()) :
				12'($urandom_range(0, grid_n - 1));
			if ($urandom_range(0, 15) == 0)
				send(OP_NONE, $urandom(), 17'($urandom()), $urandom(), $urandom(), idx);
			send(OP_READ, $urandom(), 17'($urandom_range(0, 65536)), $urandom(), $urandom(), idx);
		end
	endtask

	task automatic run_grid();
		settle();
		send(OP_RUN, $urandom(), 17'($urandom_range(0, 65536)), $urandom(), $urandom(),
			12'($urandom()));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_COLS;
		cfg_data = '0;
		opcode = OP_LOAD;
		cell_value = '0;
		face_weight = '0;
		phi_here = '0;
		phi_beside = '0;
		cell_index = '0;
		sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// register index with no register behind it
		cfg_write(reg_t'(2'd3), 32'hffffffff);
		// clamped dimensions: one interior column, then one interior row
		resize(32'h0, 32'h7f, 32'h0);
		load_cells(grid_n, 50, 1'b1);
		send(OP_NONE, 32'h0, 17'h0, 32'h0, 32'h0, 12'h0);
		run_grid();
		read_cells(6);
		resize(32'd3, 32'd64, 32'hfffffff);
		run_grid();
		send(OP_READ, 0, 0, 0, 0, 12'd4);
		send(OP_READ, 0, 0, 0, 0, 12'hfff);
		send(OP_READ, 0, 0, 0, 0, 12'(grid_n - 1));
		resize(32'd100, 32'd3, 32'd15);
		load_cells(grid_n, 10, 1'b1);
		run_grid();
		read_cells(8);
		// isolated invalid cells: no wet cells at all
		resize(32'd5, 32'd5, 32'd3);
		load_cells(grid_n, 0, 1'b1);
		run_grid();
		read_cells(6);

		while (sent < 1400) begin
			if ($urandom_range(0, 5) == 0)
				resize($urandom_range(3, 14), $urandom_range(3, 14), $urandom_range(0, 15));
			else
				resize($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(0, 15));
			load_cells(grid_n, $urandom_range(5, 60), $urandom_range(0, 3) == 0);
			read_cells($urandom_range(2, 8));
			run_grid();
			read_cells($urandom_range(5, 15));
			if ($urandom_range(0, 1)) begin
				load_cells($urandom_range(1, grid_n), 40, 1'b0);
				run_grid();
				read_cells($urandom_range(5, 12));
			end
		end
		settle();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("grid_velocity_extrapolation verification clean");
		else
			$display("grid_velocity_extrapolation verification failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("grid_velocity_extrapolation verification failed");
		$finish;
	end
endmodule
